// ===== src/gts_pkg.sv =====
`timescale 1ns / 1ps
package gts_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_RADIUS    = 3'd0;
    localparam logic [2:0] REG_WEIGHTS_A = 3'd1;
    localparam logic [2:0] REG_WEIGHTS_B = 3'd2;
    localparam logic [2:0] REG_WEIGHTS_C = 3'd3;
    localparam logic [2:0] REG_WEIGHTS_D = 3'd4;

    localparam int CFG_DATA_BITS = 64;
    localparam int SAMPLE_BITS   = 32;

    // kernel reach and window length of one track
    localparam int MAX_RADIUS = 15;
    localparam int RING_DEPTH = 2 * MAX_RADIUS + 1;

    // physical ring: window plus room for samples taken while jobs are in flight
    localparam int RING_SLOTS = 64;

    // one result job handed from front to back
    typedef struct packed {
        logic [4:0] center;     // back offset of the center sample
        logic [4:0] newest;     // index of the newest known sample
        logic       right_lim;  // track ended: no samples past newest
        logic       done;       // final result of the track
        logic [5:0] slot;       // physical ring slot of the newest sample
    } job_t;

endpackage

// ===== src/gts_front.sv =====
`timescale 1ns / 1ps
// accepts samples, writes the ring, issues result jobs
module gts_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       sample,
    input  logic              end_of_track,
    input  logic [3:0]        radius_cfg,
    output logic              ring_we,
    output logic [5:0]        ring_waddr,
    output logic [31:0]       ring_wdata,
    output logic              job_valid,
    input  logic              job_ready,
    output gts_pkg::job_t     job
);
    localparam int DEPTH = gts_pkg::RING_DEPTH;
    localparam logic [4:0] RMAX = 5'(gts_pkg::MAX_RADIUS);

    typedef enum logic [1:0] {
        S_TAKE  = 2'b01,
        S_FLUSH = 2'b10
    } fstate_t;

    fstate_t    state_reg, state_next;
    logic [5:0] slot_reg, slot_next;
    logic [4:0] seen_reg, seen_next;
    logic [4:0] c_reg, c_next;
    logic [4:0] n_reg, n_next;
    logic [5:0] nslot_reg, nslot_next;

    logic [4:0] r_eff;
    logic [4:0] seen_inc;
    logic [4:0] n_new;
    logic       take;

    assign r_eff    = ({1'b0, radius_cfg} > RMAX) ? RMAX : {1'b0, radius_cfg};
    assign in_ready = (state_reg == S_TAKE) && job_ready;
    assign take     = in_valid && in_ready;
    assign seen_inc = (seen_reg < 5'(DEPTH)) ? seen_reg + 5'd1 : seen_reg;
    assign n_new    = seen_inc - 5'd1;

    assign ring_we    = take;
    assign ring_waddr = slot_reg;
    assign ring_wdata = sample;

    // job issue
    always_comb
    begin
        job_valid     = 1'b0;
        job.center    = r_eff;
        job.newest    = n_new;
        job.right_lim = 1'b0;
        job.done      = 1'b0;
        job.slot      = slot_reg;
        if (state_reg == S_FLUSH)
        begin
            job_valid     = 1'b1;
            job.center    = c_reg;
            job.newest    = n_reg;
            job.right_lim = 1'b1;
            job.done      = (c_reg == 5'd0);
            job.slot      = nslot_reg;
        end
        else if (take && !end_of_track && n_new >= r_eff)
        begin
            job_valid = 1'b1;
        end
    end

    // track position and flush sequencing
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        seen_next  = seen_reg;
        c_next     = c_reg;
        n_next     = n_reg;
        nslot_next = nslot_reg;
        unique case (state_reg)
            S_TAKE:
            begin
                if (take)
                begin
                    // physical slot runs on across tracks
                    slot_next = slot_reg + 6'd1;
                    seen_next = seen_inc;
                    if (end_of_track)
                    begin
                        state_next = S_FLUSH;
                        c_next     = (n_new < r_eff) ? n_new : r_eff;
                        n_next     = n_new;
                        nslot_next = slot_reg;
                        seen_next  = 5'd0;
                    end
                end
            end
            S_FLUSH:
            begin
                if (job_ready)
                begin
                    if (c_reg == 5'd0)
                        state_next = S_TAKE;
                    else
                        c_next = c_reg - 5'd1;
                end
            end
            default: state_next = S_TAKE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_TAKE;
            slot_reg  <= 6'd0;
            seen_reg  <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        n_reg     <= n_next;
        nslot_reg <= nslot_next;
    end
endmodule

// ===== src/gts_queue.sv =====
`timescale 1ns / 1ps
// short job queue between front and back
module gts_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  gts_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output gts_pkg::job_t rd_job
);
    gts_pkg::job_t q_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = q_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= wr_job;
    end
endmodule

// ===== src/gts_back.sv =====
`timescale 1ns / 1ps
// weighted sum over the window, then restoring division
module gts_back #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ring_we,
    input  logic [5:0]    ring_waddr,
    input  logic [31:0]   ring_wdata,
    input  logic [3:0]    radius_cfg,
    input  logic [255:0]  weights,
    input  logic          job_valid,
    output logic          job_ready,
    input  gts_pkg::job_t job,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   smoothed,
    output logic          track_done,
    output logic          zero_weight
);
    localparam int WB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int NUMW  = 32 + WB + 6;      // signed numerator
    localparam int DENW  = WB + 6;           // denominator
    localparam int QW    = NUMW + 1;         // 2*|num|+den dividend
    localparam int PRODW = 32 + WB + 1;      // sample times weight
    localparam logic [4:0] RMAX = 5'(gts_pkg::MAX_RADIUS);
    localparam logic [5:0] QSTEPS = 6'(QW);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_ADDR = 5'b00010,
        B_MAC  = 5'b00100,
        B_DIV  = 5'b01000,
        B_OUT  = 5'b10000
    } bstate_t;

    logic [31:0] ring_mem [gts_pkg::RING_SLOTS];
    logic [31:0] rd_data_reg;

    bstate_t            state_reg, state_next;
    gts_pkg::job_t      job_reg;
    logic [4:0]         r_eff;
    // term: 0 = center, then alternate right/left over distances
    logic [5:0]         term_reg, term_next;
    logic               pend_reg;              // a read issued last cycle
    logic [WB-1:0]      pend_w_reg;
    logic               pend_use_reg;
    logic signed [NUMW-1:0] num_reg;
    logic [DENW-1:0]    den_reg;
    logic [QW-1:0]      quo_reg, rem_x_reg;
    logic [QW:0]        rem_reg;
    logic [QW-1:0]      dvs_reg;
    logic [5:0]         dcnt_reg;
    logic               neg_reg;
    logic [31:0]        res_reg;
    logic               zw_reg;

    // term decode
    logic [4:0] term_dist;
    logic       left_side;
    logic [5:0] back;
    logic       use_term;
    logic [5:0] raddr;
    logic [15:0] lane;
    logic [WB-1:0] wsel;

    logic signed [PRODW-1:0] prod_raw;
    logic [NUMW-1:0]         mag;
    logic [QW:0]             rem_sh;
    logic [QW-1:0]           qsat;
    logic [31:0]             res_reg_n;

    assign r_eff = ({1'b0, radius_cfg} > RMAX) ? RMAX : {1'b0, radius_cfg};

    always_comb
    begin
        term_dist = term_reg[5:1] + {4'd0, term_reg[0]};
        left_side = (term_reg != 6'd0) && !term_reg[0];
        back      = left_side ? {1'b0, job_reg.center} - {1'b0, term_dist}
                              : {1'b0, job_reg.center} + {1'b0, term_dist};
        if (term_reg == 6'd0)
            use_term = 1'b1;
        else if (left_side)
            use_term = !job_reg.right_lim || (term_dist <= job_reg.center);
        else
            use_term = ({1'b0, term_dist} + {1'b0, job_reg.center})
                       <= {1'b0, job_reg.newest};
        // slot = newest slot - back, wrapping over the physical ring
        raddr = job_reg.slot - back;
        lane  = weights[{term_dist[3:0], 4'd0} +: 16];
        wsel  = term_dist[4] ? '0 : lane[WB-1:0];
    end

    assign job_ready = (state_reg == B_IDLE);

    // ring memory
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_waddr] <= ring_wdata;
        rd_data_reg <= ring_mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                term_next = 6'd0;
                if (job_valid)
                    state_next = B_ADDR;
            end
            B_ADDR:
            begin
                if (term_reg == {r_eff, 1'b0})
                    state_next = B_MAC;
                else
                    term_next = term_reg + 6'd1;
            end
            // wait for the last product to land in the sum
            B_MAC:
                if (!pend_reg)
                    state_next = B_DIV;
            B_DIV:
                if (dcnt_reg == QSTEPS || den_reg == '0)
                    state_next = B_OUT;
            B_OUT:
                if (out_ready)
                    state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    assign prod_raw = $signed(rd_data_reg) * $signed({1'b0, pend_w_reg});
    assign mag  = num_reg[NUMW-1] ? NUMW'(-num_reg) : NUMW'(num_reg);
    assign rem_sh = {rem_reg[QW-1:0], rem_x_reg[QW-1]};

    always_comb
    begin
        qsat = quo_reg;
        if (neg_reg)
            res_reg_n = (qsat > QW'(33'h80000000)) ? 32'h80000000 : 32'(-qsat);
        else
            res_reg_n = (qsat > QW'(33'h7FFFFFFF)) ? 32'h7FFFFFFF : qsat[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == B_ADDR);
        end
    end

    // datapath: accumulate, then divide one bit a cycle
    always_ff @(posedge clk)
    begin
        term_reg     <= term_next;
        pend_w_reg   <= use_term ? wsel : '0;
        pend_use_reg <= use_term;
        if (state_reg == B_IDLE)
        begin
            job_reg  <= job;
            num_reg  <= '0;
            den_reg  <= '0;
        end
        else if (pend_reg && pend_use_reg)
        begin
            num_reg <= num_reg + NUMW'(prod_raw);
            den_reg <= den_reg + DENW'(pend_w_reg);
        end
        if (state_reg == B_MAC && !pend_reg)
        begin
            neg_reg   <= num_reg[NUMW-1];
            rem_x_reg <= {mag, 1'b0} + QW'(den_reg);
            dvs_reg   <= QW'({den_reg, 1'b0});
            rem_reg   <= '0;
            quo_reg   <= '0;
            dcnt_reg  <= 6'd0;
            zw_reg    <= (den_reg == '0);
        end
        else if (state_reg == B_DIV && dcnt_reg != QSTEPS)
        begin
            rem_x_reg <= {rem_x_reg[QW-2:0], 1'b0};
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_reg <= rem_sh - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 6'd1;
        end
        if (state_reg == B_DIV && state_next == B_OUT)
            res_reg <= zw_reg ? 32'd0 : res_reg_n;
    end

    assign out_valid   = (state_reg == B_OUT);
    assign smoothed    = res_reg;
    assign track_done  = job_reg.done;
    assign zero_weight = zw_reg;
endmodule

// ===== src/gaussian_track_smoother_unit.sv =====
`timescale 1ns / 1ps
// gaussian track smoother
// input channel: in_valid/in_ready with sample (Q16.16) and end_of_track.
// output channel: out_valid/out_ready with smoothed, track_done, zero_weight.
// config: cfg_we, cfg_index, cfg_data; index 0 radius, 1..4 weight lanes.
// output j of a track is produced when sample j+radius transfers; the last
// sample flushes the pending outputs, newest center last, track_done on j=last.
// each result first forms the weighted sum (one ring read per term plus the
// pipeline tail), then runs the bit-serial division, then waits in the output
// register until out_ready; a zero weight sum skips the division.
// a two-entry job queue lets the front take samples while the back works;
// when the receiver stalls, the queue fills and in_ready drops.
// the ring has 64 physical slots so samples taken ahead never overwrite a
// window still in use by a queued job.
// reset clears the track position, radius to 10, weights to zero.
module gaussian_track_smoother_unit #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] sample,
    input  logic        end_of_track,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] smoothed,
    output logic        track_done,
    output logic        zero_weight,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    logic [3:0]    radius_reg;
    logic [255:0]  weights_reg;
    logic          ring_we;
    logic [5:0]    ring_waddr;
    logic [31:0]   ring_wdata;
    logic          fj_valid, fj_ready, bj_valid, bj_ready;
    gts_pkg::job_t fj, bj;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 4'd10;
            weights_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gts_pkg::REG_RADIUS:    radius_reg <= cfg_data[3:0];
                gts_pkg::REG_WEIGHTS_A: weights_reg[63:0]    <= cfg_data;
                gts_pkg::REG_WEIGHTS_B: weights_reg[127:64]  <= cfg_data;
                gts_pkg::REG_WEIGHTS_C: weights_reg[191:128] <= cfg_data;
                gts_pkg::REG_WEIGHTS_D: weights_reg[255:192] <= cfg_data;
                default: ;
            endcase
        end
    end

    gts_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .sample, .end_of_track,
        .radius_cfg(radius_reg), .ring_we, .ring_waddr, .ring_wdata,
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    gts_queue u_queue (
        .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
    );

    gts_back #(.WEIGHT_BITS(WEIGHT_BITS)) u_back (
        .clk, .rst_n, .ring_we, .ring_waddr, .ring_wdata,
        .radius_cfg(radius_reg), .weights(weights_reg),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .out_valid, .out_ready, .smoothed, .track_done, .zero_weight
    );
endmodule

// ===== src/gts_checker.sv =====
`timescale 1ns / 1ps
// port-level checks
module gts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] smoothed,
    input logic        track_done,
    input logic        zero_weight
);
    // a pending result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(smoothed))
        else $error("result changed while stalled");

    // a zero weight sum reports zero
    a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_weight |-> smoothed == 32'd0)
        else $error("zero weight result not zero");

    // results are spaced by the division
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("back to back results");
endmodule

bind gaussian_track_smoother_unit gts_checker u_checker (
    .clk, .rst_n, .out_valid, .out_ready, .smoothed, .track_done, .zero_weight
);
